[rtl/mlc_pkg.sv]
package mlc_pkg;

	localparam int INPUT_COUNT  = 784;
	localparam int HIDDEN_COUNT = 29;
	localparam int OUTPUT_COUNT = 26;

	// Hidden store rows: pixel weights plus one bias row.
	localparam int HDEPTH  = INPUT_COUNT + 1;
	localparam int HADDR_W = $clog2(HDEPTH);
	// Output store rows: one per hidden neuron plus one bias row.
	localparam int ODEPTH  = HIDDEN_COUNT + 1;
	localparam int OADDR_W = $clog2(ODEPTH);

	localparam int TAG_RAW = ($clog2(HIDDEN_COUNT + 1) > $clog2(OUTPUT_COUNT)) ?
		$clog2(HIDDEN_COUNT + 1) : $clog2(OUTPUT_COUNT);
	localparam int TAG_W   = (TAG_RAW > 5) ? TAG_RAW : 5;

	localparam int WORD_W  = 16;
	localparam int PIX_W   = 8;
	localparam int HACC_W  = 32;
	localparam int OACC_W  = 38;
	localparam int SCORE_W = 12;
	localparam int ACT_W   = SCORE_W + 1;

	typedef enum logic [1:0] {
		ACT_HWEIGHT = 2'd0,
		ACT_OWEIGHT = 2'd1,
		ACT_PIXEL   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LASTMAC,
		ST_BIAS,
		ST_HSHIFT,
		ST_HDRAIN,
		ST_OSHIFT,
		ST_ODRAIN
	} state_t;

	typedef struct packed {
		logic mac;
		logic bias;
		logic shift;
	} hcell_ctl_t;

	typedef struct packed {
		logic mac;
		logic shift;
	} ocell_ctl_t;

	typedef struct packed {
		logic             valid;
		logic             fb24;
		logic [TAG_W-1:0] tag;
	} sig_tap_t;

	function automatic logic [SCORE_W-1:0] sig_lookup(input logic [5:0] k);
		logic [SCORE_W-1:0] v;
		case (k)
			6'd0:  v = 12'd2048;
			6'd1:  v = 12'd2303;
			6'd2:  v = 12'd2550;
			6'd3:  v = 12'd2782;
			6'd4:  v = 12'd2994;
			6'd5:  v = 12'd3184;
			6'd6:  v = 12'd3349;
			6'd7:  v = 12'd3490;
			6'd8:  v = 12'd3608;
			6'd9:  v = 12'd3705;
			6'd10: v = 12'd3785;
			6'd11: v = 12'd3850;
			6'd12: v = 12'd3902;
			6'd13: v = 12'd3943;
			6'd14: v = 12'd3976;
			6'd15: v = 12'd4002;
			6'd16: v = 12'd4022;
			6'd17: v = 12'd4038;
			6'd18: v = 12'd4051;
			6'd19: v = 12'd4061;
			6'd20: v = 12'd4069;
			6'd21: v = 12'd4075;
			6'd22: v = 12'd4079;
			6'd23: v = 12'd4083;
			6'd24: v = 12'd4086;
			6'd25: v = 12'd4088;
			6'd26: v = 12'd4090;
			6'd27: v = 12'd4091;
			6'd28: v = 12'd4092;
			6'd29: v = 12'd4093;
			6'd30: v = 12'd4094;
			6'd31: v = 12'd4094;
			default: v = 12'd4095;
		endcase
		return v;
	endfunction

	// Linear interpolation between two neighboring table points.
	function automatic logic [SCORE_W-1:0] sig_interp(input logic [4:0] idx,
		input logic [11:0] f);
		logic [SCORE_W-1:0] lo;
		logic [SCORE_W-1:0] hi;
		logic [SCORE_W-1:0] d;
		logic [23:0]        p;
		lo = sig_lookup({1'b0, idx});
		hi = sig_lookup({1'b0, idx} + 6'd1);
		d  = hi - lo;
		p  = {12'd0, d} * {12'd0, f};
		return lo + p[23:12];
	endfunction

endpackage

[rtl/mlp_letter_classifier.sv]
// Channel  Direction  Handshake          Beat contents
// in       input      in_valid/in_stall  action, row_index, column_index, weight_value,
//                                         pixel_value, last_pixel
// out      output     out_valid/out_stall letter_index, best_score
//
// Weight writes and pixels are taken one per cycle while in_stall is low; each pixel
// runs its 29 MACs in the hidden cell chain the cycle after it is read from the
// per-cell weight RAMs. A last pixel holds the input stalled while both cell chains
// are shifted through the one shared two-stage sigmoid unit; the result is raised as
// the input reopens.
// Reset clears control and accumulators; the weight RAMs hold nothing until written.
// A result still waiting from the previous image lengthens that stall at its end.
module mlp_letter_classifier
	import mlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [9:0]        row_index,
	input  logic [4:0]        column_index,
	input  logic signed [15:0] weight_value,
	input  logic [7:0]        pixel_value,
	input  logic              last_pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [4:0]        letter_index,
	output logic [11:0]       best_score
);

	state_t             state_q, state_d;
	logic [TAG_W-1:0]   cnt_q, cnt_d;
	logic               in_acc;
	logic               is_pixel;
	logic               pix_mac_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic               hw_sel;
	logic               ow_sel;
	logic               hrd_en;
	logic [HADDR_W-1:0] hrd_addr;
	logic [HADDR_W-1:0] hwr_addr;
	hcell_ctl_t         hctl;
	ocell_ctl_t         octl;
	logic signed [HACC_W-1:0] hacc [HIDDEN_COUNT];
	logic signed [OACC_W-1:0] oacc [OUTPUT_COUNT];
	logic signed [OACC_W-1:0] sig_val;
	sig_tap_t           sig_in;
	sig_tap_t           sig_s1;
	sig_tap_t           sig_s2;
	logic [SCORE_W-1:0] sig_score;
	logic               sig_busy;
	logic [ACT_W-1:0]   act;
	logic [4:0]         best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic               load;
	logic               out_valid_q;
	logic [4:0]         letter_q;
	logic [SCORE_W-1:0] score_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign is_pixel = (action == ACT_PIXEL);

	assign hw_sel = in_acc && (action == ACT_HWEIGHT) && (int'(row_index) <= INPUT_COUNT)
		&& (int'(column_index) < HIDDEN_COUNT);
	assign ow_sel = in_acc && (action == ACT_OWEIGHT) && (int'(row_index) <= HIDDEN_COUNT)
		&& (int'(column_index) < OUTPUT_COUNT);
	assign hwr_addr = (int'(row_index) <= INPUT_COUNT) ? HADDR_W'(row_index) : '0;

	always_comb begin
		if (state_q == ST_LASTMAC) begin
			hrd_en   = 1'b1;
			hrd_addr = HADDR_W'(INPUT_COUNT);
		end else begin
			hrd_en   = in_acc && is_pixel;
			hrd_addr = hwr_addr;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_mac_s1 <= 1'b0;
		end else begin
			pix_mac_s1 <= in_acc && is_pixel && (int'(row_index) < INPUT_COUNT);
		end
	end

	assign hctl.mac   = pix_mac_s1;
	assign hctl.bias  = (state_q == ST_BIAS);
	assign hctl.shift = (state_q == ST_HSHIFT);

	genvar gi;
	generate
		for (gi = 0; gi < HIDDEN_COUNT; gi++) begin : g_hcell
			logic signed [HACC_W-1:0] nxt;
			if (gi == HIDDEN_COUNT - 1) begin : g_end
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = hacc[gi+1];
			end
			mlc_hcell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.wr_en    (hw_sel && (int'(column_index) == gi)),
				.wr_addr  (hwr_addr),
				.wr_data  (weight_value),
				.rd_en    (hrd_en),
				.rd_addr  (hrd_addr),
				.ctl      (hctl),
				.pix      (pix_s1),
				.shift_in (nxt),
				.acc      (hacc[gi])
			);
		end
	endgenerate

	// The beat after the last hidden neuron carries the output bias, scaled by one.
	assign act = (sig_s2.tag == TAG_W'(HIDDEN_COUNT)) ? ACT_W'(4096) : {1'b0, sig_score};
	assign octl.mac   = sig_s2.valid && !sig_s2.fb24;
	assign octl.shift = (state_q == ST_OSHIFT);

	generate
		for (gi = 0; gi < OUTPUT_COUNT; gi++) begin : g_ocell
			logic signed [OACC_W-1:0] nxt;
			if (gi == OUTPUT_COUNT - 1) begin : g_end
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = oacc[gi+1];
			end
			mlc_ocell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.wr_en    (ow_sel && (int'(column_index) == gi)),
				.wr_addr  (OADDR_W'(row_index)),
				.wr_data  (weight_value),
				.rd_en    (sig_s1.valid && !sig_s1.fb24),
				.rd_addr  (sig_s1.tag[OADDR_W-1:0]),
				.ctl      (octl),
				.act      (act),
				.shift_in (nxt),
				.acc      (oacc[gi])
			);
		end
	endgenerate

	assign sig_val      = (state_q == ST_OSHIFT) ? oacc[0] : OACC_W'(hacc[0]);
	assign sig_in.valid = (state_q == ST_HSHIFT) || (state_q == ST_OSHIFT);
	assign sig_in.fb24  = (state_q == ST_OSHIFT);
	assign sig_in.tag   = cnt_q;

	mlc_sigmoid u_sig (
		.clk    (clk),
		.arst_n (arst_n),
		.in_val (sig_val),
		.in_tap (sig_in),
		.tap_s1 (sig_s1),
		.tap_s2 (sig_s2),
		.score  (sig_score),
		.busy   (sig_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q   <= '0;
			best_score_q <= '0;
		end else if (sig_s2.valid && sig_s2.fb24) begin
			if ((sig_s2.tag == '0) || (sig_score > best_score_q)) begin
				best_idx_q   <= sig_s2.tag[4:0];
				best_score_q <= sig_score;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_pixel && last_pixel) begin
					state_d = ST_LASTMAC;
				end
			end
			ST_LASTMAC: begin
				state_d = ST_BIAS;
			end
			ST_BIAS: begin
				state_d = ST_HSHIFT;
				cnt_d   = '0;
			end
			ST_HSHIFT: begin
				if (cnt_q == TAG_W'(HIDDEN_COUNT)) begin
					state_d = ST_HDRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_HDRAIN: begin
				if (!sig_busy) begin
					state_d = ST_OSHIFT;
					cnt_d   = '0;
				end
			end
			ST_OSHIFT: begin
				if (cnt_q == TAG_W'(OUTPUT_COUNT - 1)) begin
					state_d = ST_ODRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ODRAIN: begin
				if (!sig_busy && !out_valid_q) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			letter_q <= best_idx_q;
			score_q  <= best_score_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign letter_index = letter_q;
	assign best_score   = score_q;

`ifndef NO_ASSERTIONS
	a_tag_range: assert property (@(posedge clk) disable iff (!arst_n)
		sig_s2.valid |-> (sig_s2.fb24 ? (int'(sig_s2.tag) < OUTPUT_COUNT)
			: (int'(sig_s2.tag) <= HIDDEN_COUNT)))
		else $error("sigmoid beat carries a tag beyond its layer");
	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_ODRAIN)
		else $error("result raised outside the drain state");
	a_hidden_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OSHIFT) |-> (hacc[0] == '0))
		else $error("hidden accumulators not cleared after shift-out");
	a_mac_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		pix_mac_s1 |-> (state_q == ST_IDLE || state_q == ST_LASTMAC))
		else $error("pixel MAC outside the pixel phase");
	a_no_output_mac_in_oshift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OSHIFT) |-> !octl.mac)
		else $error("output MAC overlaps the output shift");
`endif

endmodule

[rtl/mlc_ram.sv]
module mlc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mlc_hcell.sv]
module mlc_hcell
	import mlc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [HADDR_W-1:0]       wr_addr,
	input  logic signed [WORD_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [HADDR_W-1:0]       rd_addr,
	input  hcell_ctl_t               ctl,
	input  logic [PIX_W-1:0]         pix,
	input  logic signed [HACC_W-1:0] shift_in,
	output logic signed [HACC_W-1:0] acc
);

	logic [WORD_W-1:0]           w_raw;
	logic signed [WORD_W-1:0]    w;
	logic signed [WORD_W+PIX_W:0] prod;
	logic signed [HACC_W:0]      addend;
	logic signed [HACC_W:0]      sum;
	logic signed [HACC_W-1:0]    sat;
	logic signed [HACC_W-1:0]    acc_q;

	mlc_ram #(.WIDTH(WORD_W), .DEPTH(HDEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (w_raw)
	);

	always_comb begin
		w      = $signed(w_raw);
		prod   = w * $signed({1'b0, pix});
		addend = ctl.bias ? ((HACC_W + 1)'(w) <<< 8) : (HACC_W + 1)'(prod);
		sum    = (HACC_W + 1)'(acc_q) + addend;
		// Clamp to the signed accumulator range when the top two bits disagree.
		if (sum[HACC_W] != sum[HACC_W-1]) begin
			sat = sum[HACC_W] ? {1'b1, {(HACC_W-1){1'b0}}} : {1'b0, {(HACC_W-1){1'b1}}};
		end else begin
			sat = sum[HACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= shift_in;
		end else if (ctl.bias || ctl.mac) begin
			acc_q <= sat;
		end
	end

	assign acc = acc_q;

endmodule

[rtl/mlc_ocell.sv]
module mlc_ocell
	import mlc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [OADDR_W-1:0]       wr_addr,
	input  logic signed [WORD_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [OADDR_W-1:0]       rd_addr,
	input  ocell_ctl_t               ctl,
	input  logic [ACT_W-1:0]         act,
	input  logic signed [OACC_W-1:0] shift_in,
	output logic signed [OACC_W-1:0] acc
);

	logic [WORD_W-1:0]               w_raw;
	logic signed [WORD_W+ACT_W:0]    prod;
	logic signed [OACC_W-1:0]        acc_q;

	mlc_ram #(.WIDTH(WORD_W), .DEPTH(ODEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (w_raw)
	);

	assign prod = $signed(w_raw) * $signed({1'b0, act});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= shift_in;
		end else if (ctl.mac) begin
			acc_q <= acc_q + OACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

[rtl/mlc_sigmoid.sv]
module mlc_sigmoid
	import mlc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [OACC_W-1:0] in_val,
	input  sig_tap_t                 in_tap,
	output sig_tap_t                 tap_s1,
	output sig_tap_t                 tap_s2,
	output logic [SCORE_W-1:0]       score,
	output logic                     busy
);

	logic [OACC_W-1:0]  m;
	logic [OACC_W-1:0]  m_sh;
	logic               neg_s1;
	logic               big_s1;
	logic [4:0]         idx_s1;
	logic [11:0]        f_s1;
	logic [SCORE_W:0]   s;
	logic [SCORE_W:0]   r;
	logic [SCORE_W-1:0] score_s2;
	sig_tap_t           tap1_q;
	sig_tap_t           tap2_q;

	assign m    = in_val[OACC_W-1] ? OACC_W'(-in_val) : OACC_W'(in_val);
	assign m_sh = in_tap.fb24 ? (m >> 22) : (m >> 18);

	always_ff @(posedge clk) begin
		neg_s1 <= in_val[OACC_W-1];
		big_s1 <= |m_sh[OACC_W-1:5];
		idx_s1 <= m_sh[4:0];
		f_s1   <= in_tap.fb24 ? m[23:12] : m[19:8];
	end

	always_comb begin
		s = big_s1 ? (SCORE_W + 1)'(4095) : {1'b0, sig_interp(idx_s1, f_s1)};
		r = neg_s1 ? ((SCORE_W + 1)'(4096) - s) : s;
		if (r > (SCORE_W + 1)'(4095)) begin
			r = (SCORE_W + 1)'(4095);
		end
	end

	always_ff @(posedge clk) begin
		score_s2 <= r[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap1_q <= '0;
			tap2_q <= '0;
		end else begin
			tap1_q <= in_tap;
			tap2_q <= tap1_q;
		end
	end

	assign tap_s1 = tap1_q;
	assign tap_s2 = tap2_q;
	assign score  = score_s2;
	assign busy   = tap1_q.valid || tap2_q.valid;

endmodule
